// ===== hdl/lmps_pkg.sv =====
`default_nettype none
package lmps_pkg;

	localparam int DEF_COLUMNS  = 4;
	localparam int DEF_CHANNELS = 15;

	localparam int LEVEL_W    = 8;
	localparam int DRIVE_W    = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [LEVEL_W-1:0] RST_LEVEL_STEP  = 8'd13;
	localparam logic [LEVEL_W-1:0] RST_LEVEL_LIMIT = 8'd250;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL_STEP  = 1'b0,
		REG_LEVEL_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_SHIFT = 2'd0,
		PH_LATCH = 2'd1,
		PH_END   = 2'd2
	} phase_t;

	// what one tick carries from the counter stage to the compare stage
	typedef struct packed {
		phase_t               kind;
		logic [DRIVE_W-1:0]   drive;
		logic [LEVEL_W-1:0]   level;
	} step_t;

endpackage
`default_nettype wire

// ===== hdl/lmps_ram.sv =====
`default_nettype none
module lmps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             re,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		// read data holds while re is low
		if (re) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/led_matrix_pwm_scanner.sv =====
`default_nettype none
// channel   handshake            payload
// req       req_valid/req_stall  req_type, pixel_column, pixel_channel, pixel_value
// rsp       rsp_valid/rsp_stall  column_drive, serial_bit, shift_strobe,
//                                latch_strobe, frame_done
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle unless req_stall is high; a tick passes the counter stage,
// then the frame buffer read and threshold compare into the output register
// after reset the frame buffer is zeroed, one entry a cycle, all COLUMNS * 2^clog2(CHANNELS)
// entries (64 by default); req_stall stays high meanwhile, cfg writes are taken
// rsp_stall holds the pipeline; req_stall rises during the clear, or when both stages are full and rsp_stall is high
module led_matrix_pwm_scanner #(
	parameter int COLUMNS  = lmps_pkg::DEF_COLUMNS,
	parameter int CHANNELS = lmps_pkg::DEF_CHANNELS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic                            req_type,
	input  wire logic [1:0]                      pixel_column,
	input  wire logic [3:0]                      pixel_channel,
	input  wire logic [7:0]                      pixel_value,

	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output logic [lmps_pkg::DRIVE_W-1:0]         column_drive,
	output logic                                 serial_bit,
	output logic                                 shift_strobe,
	output logic                                 latch_strobe,
	output logic                                 frame_done,

	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lmps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lmps_pkg::CFG_DATA_W-1:0] cfg_data
);

	import lmps_pkg::*;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int CH_W   = $clog2(CHANNELS);
	localparam int ADDR_W = COL_W + CH_W;
	localparam int DEPTH  = COLUMNS << CH_W;

	// configuration
	logic [LEVEL_W-1:0] level_step_q;
	logic [LEVEL_W-1:0] level_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_step_q  <= RST_LEVEL_STEP;
			level_limit_q <= RST_LEVEL_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_LEVEL_STEP:  level_step_q  <= cfg_data;
				REG_LEVEL_LIMIT: level_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame buffer clearing pass
	logic              clr_active_q;
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// handshake and pipeline control
	logic  s1_valid_q;
	step_t step_s1;
	logic  s1_adv;
	logic  req_go;
	logic  tick_go;

	assign s1_adv    = s1_valid_q && (!rsp_valid || !rsp_stall);
	assign req_stall = clr_active_q || (s1_valid_q && rsp_valid && rsp_stall);
	assign req_go    = req_valid && !req_stall;
	assign tick_go   = req_go && req_type;

	// scan counters
	phase_t             phase_q, phase_d;
	logic [CH_W-1:0]    bit_pos_q, bit_pos_d;
	logic [COL_W-1:0]   shift_col_q, shift_col_d;
	logic [COL_W-1:0]   lit_col_q, lit_col_d;
	logic [LEVEL_W-1:0] level_q, level_d;
	logic [LEVEL_W:0]   level_sum;

	assign level_sum = {1'b0, level_q} + {1'b0, level_step_q};

	always_comb begin
		phase_d     = phase_q;
		bit_pos_d   = bit_pos_q;
		shift_col_d = shift_col_q;
		lit_col_d   = lit_col_q;
		level_d     = level_q;
		case (phase_q)
			PH_SHIFT: begin
				if (bit_pos_q == '0) begin
					phase_d = PH_LATCH;
				end else begin
					bit_pos_d = bit_pos_q - 1'b1;
				end
			end
			PH_LATCH: begin
				lit_col_d = shift_col_q;
				bit_pos_d = CH_W'(CHANNELS - 1);
				phase_d   = PH_SHIFT;
				if (shift_col_q == COL_W'(COLUMNS - 1)) begin
					shift_col_d = '0;
					// sum taken one bit wider so the level never wraps
					if (level_sum >= {1'b0, level_limit_q}) begin
						phase_d = PH_END;
					end else begin
						level_d = level_sum[LEVEL_W-1:0];
					end
				end else begin
					shift_col_d = shift_col_q + 1'b1;
				end
			end
			PH_END: begin
				level_d     = '0;
				shift_col_d = '0;
				bit_pos_d   = CH_W'(CHANNELS - 1);
				phase_d     = PH_SHIFT;
			end
			default: begin
				phase_d = PH_SHIFT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SHIFT;
			bit_pos_q   <= CH_W'(CHANNELS - 1);
			shift_col_q <= '0;
			lit_col_q   <= COL_W'(COLUMNS - 1);
			level_q     <= '0;
		end else if (tick_go) begin
			phase_q     <= phase_d;
			bit_pos_q   <= bit_pos_d;
			shift_col_q <= shift_col_d;
			lit_col_q   <= lit_col_d;
			level_q     <= level_d;
		end
	end

	// step fields known before the buffer read
	step_t step_d;

	always_comb begin
		step_d.kind  = phase_q;
		step_d.level = level_q;
		if (phase_q == PH_SHIFT) begin
			step_d.drive = DRIVE_W'({{(DRIVE_W-1){1'b0}}, 1'b1} << lit_col_q);
		end else begin
			step_d.drive = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (tick_go) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			step_s1 <= step_d;
		end
	end

	// frame buffer ports
	logic [COL_W+1:0]   wr_col_ext;
	logic [CH_W+3:0]    wr_ch_ext;
	logic               wr_in_range;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_wr_addr;
	logic [LEVEL_W-1:0] ram_wr_data;
	logic [LEVEL_W-1:0] ram_rd_data;

	assign wr_col_ext  = (COL_W + 2)'(pixel_column);
	assign wr_ch_ext   = (CH_W + 4)'(pixel_channel);
	assign wr_in_range = (wr_col_ext < (COL_W + 2)'(COLUMNS)) &&
		(wr_ch_ext < (CH_W + 4)'(CHANNELS));

	always_comb begin
		if (clr_active_q) begin
			ram_we      = 1'b1;
			ram_wr_addr = clr_addr_q;
			ram_wr_data = '0;
		end else begin
			ram_we      = req_go && !req_type && wr_in_range;
			ram_wr_addr = {wr_col_ext[COL_W-1:0], wr_ch_ext[CH_W-1:0]};
			ram_wr_data = pixel_value;
		end
	end

	lmps_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (DEPTH)
	) u_frame_buf (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.re      (tick_go),
		.rd_addr ({shift_col_q, bit_pos_q}),
		.rd_data (ram_rd_data)
	);

	// threshold compare into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			column_drive <= step_s1.drive;
			serial_bit   <= (step_s1.kind == PH_SHIFT) && (ram_rd_data >= step_s1.level);
			shift_strobe <= step_s1.kind == PH_SHIFT;
			latch_strobe <= step_s1.kind == PH_LATCH;
			frame_done   <= step_s1.kind == PH_END;
		end
	end

	a_clear_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> req_stall)
		else $error("item taken during buffer clear");

	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot({shift_strobe, latch_strobe, frame_done}))
		else $error("result is not exactly one kind of step");

	a_blank_off_shift: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !shift_strobe |-> column_drive == '0 && serial_bit == 1'b0)
		else $error("columns or data active on a latch or end step");

	a_end_counters: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_END |-> shift_col_q == '0 && bit_pos_q == CH_W'(CHANNELS - 1))
		else $error("counters not rewound before frame end");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && rsp_valid && rsp_stall |=> s1_valid_q)
		else $error("held tick lost from compare stage");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import lmps_pkg::*;

	localparam int NCOLS        = DEF_COLUMNS;
	localparam int NCHANS       = DEF_CHANNELS;
	localparam int PIPE_SLACK   = 6;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int FIRST_QUOTA  = 230;
	localparam int PHASE_QUOTA  = 215;
	localparam int PHASE_COUNT  = 9;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_TICK  = 1'b1
	} req_kind_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct packed {
		req_kind_t  req_type;
		logic [1:0] column;
		logic [3:0] channel;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic [3:0] column_drive;
		logic       serial_bit;
		logic       shift_strobe;
		logic       latch_strobe;
		logic       frame_done;
	} pin_step_t;

	typedef struct packed {
		req_t      req;
		logic      typed;
		pin_step_t want;
	} dir_row_t;

	localparam req_t      TICK_REQ = '{REQ_TICK, 2'd0, 4'd0, 8'd0};
	localparam pin_step_t NO_CHECK = '0;

	logic clk = 1'b0;
	logic arst_n;

	logic       req_valid;
	logic       req_stall;
	logic       req_type;
	logic [1:0] pixel_column;
	logic [3:0] pixel_channel;
	logic [7:0] pixel_value;

	logic       rsp_valid;
	logic       rsp_stall;
	logic [3:0] column_drive;
	logic       serial_bit;
	logic       shift_strobe;
	logic       latch_strobe;
	logic       frame_done;

	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	led_matrix_pwm_scanner uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.pixel_column  (pixel_column),
		.pixel_channel (pixel_channel),
		.pixel_value   (pixel_value),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.column_drive  (column_drive),
		.serial_bit    (serial_bit),
		.shift_strobe  (shift_strobe),
		.latch_strobe  (latch_strobe),
		.frame_done    (frame_done),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scanner state as the predictor sees it
	logic [7:0] frame_img [NCOLS][NCHANS];
	logic [7:0] cur_level;
	logic [1:0] scan_col;
	logic [1:0] lit_col;
	logic [3:0] bit_idx;
	phase_t     step_phase;
	logic [7:0] step_reg;
	logic [7:0] limit_reg;

	pin_step_t   expected_steps [$];
	int          fails;
	int          cycles;
	stall_mode_t stall_mode;
	int          stall_cnt;

	function automatic bit predict_pin_step(input req_t r, output pin_step_t s);
		logic [8:0] next_level;
		s = '0;
		if (r.req_type == REQ_WRITE) begin
			if (r.channel < NCHANS)
				frame_img[r.column][r.channel] = r.value;
			return 1'b0;
		end
		case (step_phase)
			PH_SHIFT: begin
				s.column_drive = 4'b0001 << lit_col;
				s.serial_bit   = frame_img[scan_col][bit_idx] >= cur_level;
				s.shift_strobe = 1'b1;
				if (bit_idx == 0)
					step_phase = PH_LATCH;
				else
					bit_idx--;
			end
			PH_LATCH: begin
				s.latch_strobe = 1'b1;
				lit_col    = scan_col;
				bit_idx    = 4'(NCHANS - 1);
				step_phase = PH_SHIFT;
				if (scan_col == 2'(NCOLS - 1)) begin
					// compare at full width, no 8-bit wrap
					next_level = {1'b0, cur_level} + {1'b0, step_reg};
					scan_col   = '0;
					if (next_level >= {1'b0, limit_reg})
						step_phase = PH_END;
					else
						cur_level = next_level[7:0];
				end else begin
					scan_col++;
				end
			end
			default: begin
				s.frame_done = 1'b1;
				cur_level    = '0;
				scan_col     = '0;
				bit_idx      = 4'(NCHANS - 1);
				step_phase   = PH_SHIFT;
			end
		endcase
		return 1'b1;
	endfunction

	task automatic send_request(input req_t r, input logic typed, input pin_step_t want);
		pin_step_t s;
		@(negedge clk);
		req_valid     <= 1'b1;
		req_type      <= r.req_type;
		pixel_column  <= r.column;
		pixel_channel <= r.channel;
		pixel_value   <= r.value;
		do @(posedge clk); while (req_stall);
		if (predict_pin_step(r, s))
			expected_steps.push_back(typed ? want : s);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_LEVEL_STEP)
			step_reg = data;
		else
			limit_reg = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// lets the last ticks and any trailing writes leave the pipeline
	task automatic settle();
		while (expected_steps.size() != 0) @(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	task automatic run_random(input int quota, input bit steady);
		req_t r;
		int   counted;
		int   burst;
		int   gap;
		counted = 0;
		burst   = 0;
		while (counted < quota) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				gap   = steady ? 0 : $urandom_range(0, 6);
				repeat (gap) begin
					@(negedge clk);
					req_valid <= 1'b0;
				end
			end
			r.req_type = ($urandom_range(0, 4) == 0) ? REQ_WRITE : REQ_TICK;
			r.column   = 2'($urandom_range(0, 3));
			r.channel  = 4'($urandom_range(0, 15));
			case ($urandom_range(0, 5))
				0:       r.value = 8'h00;
				1:       r.value = 8'hff;
				default: r.value = 8'($urandom_range(0, 255));
			endcase
			send_request(r, 1'b0, NO_CHECK);
			burst--;
			// writes to a channel past the end are dropped by the block
			if (r.req_type == REQ_TICK || r.channel < NCHANS)
				counted++;
		end
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		stall_cnt <= stall_cnt + 1;
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
			default:     rsp_stall <= (stall_cnt % 9) < 4;
		endcase
	end

	always @(posedge clk) begin : check_results
		pin_step_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_steps.size() == 0) begin
				$error("result transfer with nothing expected");
				fails++;
			end else begin
				want = expected_steps.pop_front();
				if (column_drive !== want.column_drive) begin
					$error("column_drive: expected %0h, got %0h", want.column_drive,
						column_drive);
					fails++;
				end
				if (serial_bit !== want.serial_bit) begin
					$error("serial_bit: expected %0b, got %0b", want.serial_bit, serial_bit);
					fails++;
				end
				if (shift_strobe !== want.shift_strobe) begin
					$error("shift_strobe: expected %0b, got %0b", want.shift_strobe,
						shift_strobe);
					fails++;
				end
				if (latch_strobe !== want.latch_strobe) begin
					$error("latch_strobe: expected %0b, got %0b", want.latch_strobe,
						latch_strobe);
					fails++;
				end
				if (frame_done !== want.frame_done) begin
					$error("frame_done: expected %0b, got %0b", want.frame_done, frame_done);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("led_matrix_pwm_scanner: mismatch");
			$finish;
		end
	end

	initial begin
		dir_row_t   directed_rows [23];
		logic [7:0] phase_step;
		logic [7:0] phase_limit;
		int         ph;

		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req_type      = REQ_WRITE;
		pixel_column  = '0;
		pixel_channel = '0;
		pixel_value   = '0;
		rsp_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_LEVEL_STEP;
		cfg_data      = '0;
		fails         = 0;
		cycles        = 0;
		stall_cnt     = 0;
		stall_mode    = STALL_PERIODIC;

		foreach (frame_img[c, k])
			frame_img[c][k] = '0;
		cur_level  = '0;
		scan_col   = '0;
		lit_col    = 2'(NCOLS - 1);
		bit_idx    = 4'(NCHANS - 1);
		step_phase = PH_SHIFT;
		step_reg   = RST_LEVEL_STEP;
		limit_reg  = RST_LEVEL_LIMIT;

		directed_rows = '{
			// first step after reset: column 3 still lit, cleared byte passes level 0
			'{TICK_REQ, 1'b1, '{4'b1000, 1'b1, 1'b1, 1'b0, 1'b0}},
			'{'{REQ_WRITE, 2'd0, 4'd14, 8'hff}, 1'b0, NO_CHECK},
			'{'{REQ_WRITE, 2'd3, 4'd0,  8'h00}, 1'b0, NO_CHECK},
			// channel past the end, dropped
			'{'{REQ_WRITE, 2'd2, 4'd15, 8'haa}, 1'b0, NO_CHECK},
			'{'{REQ_WRITE, 2'd1, 4'd7,  8'h80}, 1'b0, NO_CHECK},
			'{'{REQ_WRITE, 2'd0, 4'd13, 8'h55}, 1'b0, NO_CHECK},
			'{'{REQ_WRITE, 2'd0, 4'd0,  8'h01}, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			'{TICK_REQ, 1'b0, NO_CHECK},
			// latch step: columns blanked, no data
			'{TICK_REQ, 1'b1, '{4'b0000, 1'b0, 1'b0, 1'b1, 1'b0}},
			// column 0 now lit while column 1 shifts
			'{TICK_REQ, 1'b1, '{4'b0001, 1'b1, 1'b1, 1'b0, 1'b0}}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			stall_mode = stall_mode_t'(ph % 4);
			if (ph > 0) begin
				case (ph)
					1: begin phase_step = 8'd255; phase_limit = 8'd255; end
					2: begin phase_step = 8'd0;   phase_limit = 8'd0;   end
					3: begin phase_step = 8'd0;   phase_limit = 8'd1;   end
					4: begin phase_step = 8'd1;   phase_limit = 8'd255; end
					5: begin phase_step = 8'd128; phase_limit = 8'd1;   end
					6: begin
						phase_step  = 8'($urandom_range(1, 255));
						phase_limit = 8'($urandom_range(1, 255));
					end
					7: begin
						phase_step  = 8'($urandom_range(1, 32));
						phase_limit = 8'($urandom_range(128, 255));
					end
					default: begin
						phase_step  = RST_LEVEL_STEP;
						phase_limit = RST_LEVEL_LIMIT;
					end
				endcase
				settle();
				write_reg(REG_LEVEL_STEP, phase_step);
				write_reg(REG_LEVEL_LIMIT, phase_limit);
			end
			run_random(ph == 0 ? FIRST_QUOTA : PHASE_QUOTA, ph == 3 || ph == 6);
		end

		settle();
		if (fails == 0 && expected_steps.size() == 0)
			$display("led_matrix_pwm_scanner: match");
		else
			$display("led_matrix_pwm_scanner: mismatch");
		$finish;
	end

endmodule
